>>> design/jsa_pkg.sv
// shared types and constants for the joystick stepper with auto-repeat
`default_nettype none

package jsa_pkg;

  // request kinds
  localparam logic [1:0] KIND_POLL          = 2'd0;
  localparam logic [1:0] KIND_PRELOAD_VERT  = 2'd1;
  localparam logic [1:0] KIND_PRELOAD_HORIZ = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERT_MIN   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERT_MAX   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VERT_STEP  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HORIZ_MIN  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HORIZ_MAX  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HORIZ_STEP = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE_FLAGS = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_MS  = 3'd7;

  // mode flag bit positions
  localparam int MODE_VERT_EN   = 0;
  localparam int MODE_VERT_WRAP = 1;
  localparam int MODE_HORIZ_EN  = 2;
  localparam int MODE_HORIZ_WRAP = 3;

  localparam logic signed [7:0] STEP_THRESHOLD = 8'sd64;
  localparam logic signed [7:0] DEAD_ZONE      = 8'sd16;
  localparam logic [15:0]       REPEAT_RESET   = 16'd200;
  localparam logic [6:0]        STEP_RESET     = 7'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [7:0] axis_x;
    logic signed [7:0] axis_y;
    logic [7:0]        elapsed_ms;
    logic signed [7:0] preload_value;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] vert_value;
    logic signed [7:0] horiz_value;
    logic              vert_changed;
    logic              horiz_changed;
  } out_item_t;

  // per-axis configuration
  typedef struct packed {
    logic signed [7:0] min_val;
    logic signed [7:0] max_val;
    logic [6:0]        step;
    logic              enable;
    logic              wrap;
  } axis_cfg_t;

  // per-axis command for one request
  typedef struct packed {
    logic poll;
    logic preload;
    logic move_up;
    logic move_down;
  } axis_cmd_t;

endpackage

`default_nettype wire

>>> design/jsa_if.sv
// valid/ready channel interfaces for requests and results
`default_nettype none

interface jsa_in_if;
  logic               valid;
  logic               ready;
  jsa_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jsa_out_if;
  logic               valid;
  logic               ready;
  jsa_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/joystick_stepper_autorepeat.sv
// Joystick stepper with auto-repeat: two axes turned into stepped values.
// Requests come in on items (valid/ready). Kind poll samples both axes:
// a deflection beyond +-64 steps the axis value by its step, limited by
// min/max with wrap or clamp, and gated by a repeat delay once armed;
// a return into the +-16 dead zone disarms. Kinds preload vertical and
// preload horizontal write a value. Every request gives one result on
// results: both values and a changed flag for each axis.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle; the block does not enforce this. A
// request is worked out from the input register. Throughput is one
// request per clock unless results stalls; the axis state updates in the
// same cycle the request moves into the result register, so back-to-back
// requests see fresh state. On a stall the result register holds and
// items.ready drops once the input register is full.
// Reset (synchronous, rst high) clears values, timers and arm bits,
// empties both registers and restores the configuration defaults.
`default_nettype none

module joystick_stepper_autorepeat #(
  parameter int TIMER_BITS = 16
) (
  input  wire                                         clk,
  input  wire                                         rst,
  jsa_in_if.sink                                      items,
  jsa_out_if.source                                   results,
  input  wire                                         cfg_we,
  input  wire logic [jsa_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [jsa_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  // configuration registers
  logic signed [7:0] vert_min;
  logic signed [7:0] vert_max;
  logic [6:0]        vert_step;
  logic signed [7:0] horiz_min;
  logic signed [7:0] horiz_max;
  logic [6:0]        horiz_step;
  logic [3:0]        mode_flags;
  logic [15:0]       repeat_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_min   <= '0;
      vert_max   <= '0;
      vert_step  <= jsa_pkg::STEP_RESET;
      horiz_min  <= '0;
      horiz_max  <= '0;
      horiz_step <= jsa_pkg::STEP_RESET;
      mode_flags <= '0;
      repeat_ms  <= jsa_pkg::REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        jsa_pkg::CFG_VERT_MIN:   vert_min   <= cfg_data[7:0];
        jsa_pkg::CFG_VERT_MAX:   vert_max   <= cfg_data[7:0];
        jsa_pkg::CFG_VERT_STEP:  vert_step  <= cfg_data[6:0];
        jsa_pkg::CFG_HORIZ_MIN:  horiz_min  <= cfg_data[7:0];
        jsa_pkg::CFG_HORIZ_MAX:  horiz_max  <= cfg_data[7:0];
        jsa_pkg::CFG_HORIZ_STEP: horiz_step <= cfg_data[6:0];
        jsa_pkg::CFG_MODE_FLAGS: mode_flags <= cfg_data[3:0];
        jsa_pkg::CFG_REPEAT_MS:  repeat_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              req_valid;
  jsa_pkg::in_item_t req;
  logic              advance;

  // result register
  logic               rsp_valid;
  jsa_pkg::out_item_t rsp;

  assign advance     = req_valid && (!rsp_valid || results.ready);
  assign items.ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (items.ready) begin
      req_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      req <= items.data;
    end
  end

  // per-axis decode
  jsa_pkg::axis_cfg_t vert_cfg;
  jsa_pkg::axis_cfg_t horiz_cfg;
  jsa_pkg::axis_cmd_t vert_cmd;
  jsa_pkg::axis_cmd_t horiz_cmd;
  logic               is_poll;
  logic signed [7:0]  vert_value_next;
  logic signed [7:0]  horiz_value_next;
  logic               vert_stepped;
  logic               horiz_stepped;

  always_comb begin
    is_poll = advance && (req.kind == jsa_pkg::KIND_POLL);

    vert_cfg.min_val = vert_min;
    vert_cfg.max_val = vert_max;
    vert_cfg.step    = vert_step;
    vert_cfg.enable  = mode_flags[jsa_pkg::MODE_VERT_EN];
    vert_cfg.wrap    = mode_flags[jsa_pkg::MODE_VERT_WRAP];

    horiz_cfg.min_val = horiz_min;
    horiz_cfg.max_val = horiz_max;
    horiz_cfg.step    = horiz_step;
    horiz_cfg.enable  = mode_flags[jsa_pkg::MODE_HORIZ_EN];
    horiz_cfg.wrap    = mode_flags[jsa_pkg::MODE_HORIZ_WRAP];

    // positive vertical deflection counts down
    vert_cmd.poll      = is_poll;
    vert_cmd.preload   = advance && (req.kind == jsa_pkg::KIND_PRELOAD_VERT);
    vert_cmd.move_up   = req.axis_y < -jsa_pkg::STEP_THRESHOLD;
    vert_cmd.move_down = req.axis_y > jsa_pkg::STEP_THRESHOLD;

    horiz_cmd.poll      = is_poll;
    horiz_cmd.preload   = advance && (req.kind == jsa_pkg::KIND_PRELOAD_HORIZ);
    horiz_cmd.move_up   = req.axis_x > jsa_pkg::STEP_THRESHOLD;
    horiz_cmd.move_down = req.axis_x < -jsa_pkg::STEP_THRESHOLD;
  end

  jsa_axis #(
    .TIMER_BITS (TIMER_BITS)
  ) u_vert (
    .clk           (clk),
    .rst           (rst),
    .cfg           (vert_cfg),
    .repeat_ms     (repeat_ms),
    .cmd           (vert_cmd),
    .sample        (req.axis_y),
    .elapsed_ms    (req.elapsed_ms),
    .preload_value (req.preload_value),
    .value_next    (vert_value_next),
    .stepped       (vert_stepped)
  );

  jsa_axis #(
    .TIMER_BITS (TIMER_BITS)
  ) u_horiz (
    .clk           (clk),
    .rst           (rst),
    .cfg           (horiz_cfg),
    .repeat_ms     (repeat_ms),
    .cmd           (horiz_cmd),
    .sample        (req.axis_x),
    .elapsed_ms    (req.elapsed_ms),
    .preload_value (req.preload_value),
    .value_next    (horiz_value_next),
    .stepped       (horiz_stepped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (results.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.vert_value    <= vert_value_next;
      rsp.horiz_value   <= horiz_value_next;
      rsp.vert_changed  <= vert_stepped;
      rsp.horiz_changed <= horiz_stepped;
    end
  end

  assign results.valid = rsp_valid;
  assign results.data  = rsp;

endmodule

`default_nettype wire

>>> design/jsa_axis.sv
// one axis: stepped value, saturating repeat timer and repeat arm bit
`default_nettype none

module jsa_axis #(
  parameter int TIMER_BITS = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire jsa_pkg::axis_cfg_t   cfg,
  input  wire logic [15:0]          repeat_ms,
  input  wire jsa_pkg::axis_cmd_t   cmd,
  input  wire logic signed [7:0]    sample,
  input  wire logic [7:0]           elapsed_ms,
  input  wire logic signed [7:0]    preload_value,
  output logic signed [7:0]         value_next,
  output logic                      stepped
);

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic signed [7:0]       value;
  logic [TIMER_BITS-1:0]   timer;
  logic                    armed;

  logic [TIMER_BITS:0]     timer_sum;
  logic [TIMER_BITS-1:0]   timer_add;
  logic [TIMER_BITS-1:0]   timer_next;
  logic                    armed_next;
  logic                    active;
  logic                    gate;
  logic                    in_dead_zone;
  logic signed [9:0]       value_w;
  logic signed [9:0]       step_w;
  logic signed [9:0]       sum_up;
  logic signed [9:0]       sum_down;
  logic signed [7:0]       stepped_value;

  always_comb begin
    timer_sum = (TIMER_BITS+1)'(timer) + (TIMER_BITS+1)'(elapsed_ms);
    timer_add = timer_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : timer_sum[TIMER_BITS-1:0];

    active = cfg.enable && (cfg.max_val > cfg.min_val);
    gate   = !armed || (CMP_W'(timer_add) >= CMP_W'(repeat_ms));
    in_dead_zone = (sample > -jsa_pkg::DEAD_ZONE) && (sample < jsa_pkg::DEAD_ZONE);
    stepped = cmd.poll && active && (cmd.move_up || cmd.move_down) && gate;

    value_w  = 10'(value);
    step_w   = signed'(10'(cfg.step));
    sum_up   = value_w + step_w;
    sum_down = value_w - step_w;

    // past a limit: wrap to the opposite one or clamp
    if (cmd.move_up) begin
      if (sum_up <= 10'(cfg.max_val)) begin
        stepped_value = sum_up[7:0];
      end else begin
        stepped_value = cfg.wrap ? cfg.min_val : cfg.max_val;
      end
    end else begin
      if (sum_down >= 10'(cfg.min_val)) begin
        stepped_value = sum_down[7:0];
      end else begin
        stepped_value = cfg.wrap ? cfg.max_val : cfg.min_val;
      end
    end

    value_next = value;
    if (cmd.preload) begin
      value_next = preload_value;
    end else if (stepped) begin
      value_next = stepped_value;
    end

    // timers run on every poll, enabled or not
    timer_next = timer;
    if (cmd.poll) begin
      timer_next = stepped ? '0 : timer_add;
    end

    armed_next = armed;
    if (cmd.poll && active) begin
      if (stepped) begin
        armed_next = 1'b1;
      end else if (in_dead_zone) begin
        armed_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      timer <= '0;
      armed <= 1'b0;
    end else begin
      value <= value_next;
      timer <= timer_next;
      armed <= armed_next;
    end
  end

endmodule

`default_nettype wire
